// ===== rtl/core/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg
// Types, constants and byte-step functions shared by the sync frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'h0000;
    localparam logic [7:0]  TYPE_ACK = 8'h0F;
    localparam logic [7:0]  TYPE_U02 = 8'h02;
    localparam logic [7:0]  TYPE_U20 = 8'h20;
    localparam logic [7:0]  TYPE_U21 = 8'h21;
    localparam logic [7:0]  TYPE_U30 = 8'h30;
    localparam logic [7:0]  TYPE_U33 = 8'h33;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_RX_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SYNC  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_SYNC = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd3;

    localparam logic        RST_RX_ENABLE   = 1'b1;
    localparam logic [7:0]  RST_FIRST_SYNC  = 8'hAA;
    localparam logic [7:0]  RST_SECOND_SYNC = 8'h55;
    localparam logic [15:0] RST_MAX_PAYLOAD = 16'd512;

    typedef struct packed {
        logic        receive_enable;
        logic [7:0]  first_sync;
        logic [7:0]  second_sync;
        logic [15:0] max_payload;
    } t_cfg;

    typedef enum logic [9:0] {
        PH_SYNC0   = 10'b00_0000_0001,
        PH_SYNC1   = 10'b00_0000_0010,
        PH_TYPE    = 10'b00_0000_0100,
        PH_SEQ_HI  = 10'b00_0000_1000,
        PH_SEQ_LO  = 10'b00_0001_0000,
        PH_LEN_HI  = 10'b00_0010_0000,
        PH_LEN_LO  = 10'b00_0100_0000,
        PH_PAYLOAD = 10'b00_1000_0000,
        PH_CRC_LO  = 10'b01_0000_0000,
        PH_CRC_HI  = 10'b10_0000_0000
    } t_phase;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef struct packed {
        logic        valid;
        logic        kind;
        logic [7:0]  data_byte;
        logic [7:0]  frame_type;
        logic [15:0] sequence_res;
        logic [15:0] payload_length;
        logic        crc_ok;
        logic        is_ack;
        logic        ack_required;
    } t_result;

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic type_reliable(input logic [7:0] t);
        return !(t == TYPE_U02 || t == TYPE_ACK || t == TYPE_U20 ||
                 t == TYPE_U21 || t == TYPE_U30 || t == TYPE_U33);
    endfunction

endpackage

// ===== rtl/core/sync_frame_deframer_crc16.sv =====
// An item is held in the input register once accepted, and its result, if any, is
// registered in the result register when the item advances.
// Throughput: one byte per cycle unless the output stalls; the CRC steps bytewise.
// While a result waits on a stalled output, the input register takes one more byte
// and then stalls the input. Reset is synchronous and active low; it restores the
// register defaults and the hunt.
// ----------------------------------------------------------------------------
// sync_frame_deframer_crc16
// Sync-word frame deframer with an incremental CRC16-XMODEM check.
// ----------------------------------------------------------------------------
module sync_frame_deframer_crc16 (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sfd_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_rx_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_kind,
    output logic [7:0]                     o_data_byte,
    output logic [7:0]                     o_frame_type,
    output logic [15:0]                    o_sequence_res,
    output logic [15:0]                    o_payload_length,
    output logic                           o_crc_ok,
    output logic                           o_is_ack,
    output logic                           o_ack_required
);
    import sfd_pkg::*;

    t_cfg       cfg;
    t_result    result;
    t_result    r_out;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       advance;
    logic       in_accept;

    assign advance    = r_in_valid && !(r_out.valid && i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    sfd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    sfd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_byte   (r_in_byte),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else if (advance && result.valid) begin
            r_out.valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out.valid <= 1'b0;
        end
        if (advance && result.valid) begin
            r_out.kind           <= result.kind;
            r_out.data_byte      <= result.data_byte;
            r_out.frame_type     <= result.frame_type;
            r_out.sequence_res   <= result.sequence_res;
            r_out.payload_length <= result.payload_length;
            r_out.crc_ok         <= result.crc_ok;
            r_out.is_ack         <= result.is_ack;
            r_out.ack_required   <= result.ack_required;
        end
    end

    assign o_out_valid      = r_out.valid;
    assign o_kind           = r_out.kind;
    assign o_data_byte      = r_out.data_byte;
    assign o_frame_type     = r_out.frame_type;
    assign o_sequence_res   = r_out.sequence_res;
    assign o_payload_length = r_out.payload_length;
    assign o_crc_ok         = r_out.crc_ok;
    assign o_is_ack         = r_out.is_ack;
    assign o_ack_required   = r_out.ack_required;

`ifndef SYNTHESIS
    a_report_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_REPORT) |-> o_data_byte == 8'h00)
        else $error("end of frame report carries a data byte");

    a_bad_crc_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_crc_ok |-> !o_is_ack && !o_ack_required)
        else $error("ack flags set on a frame with a bad CRC");

    a_ack_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_ack |-> !o_ack_required)
        else $error("acknowledge frame marked as requiring an ack");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && o_out_valid && i_out_stall)
        else $error("input stalled without a blocked result");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_in_valid && r_in_byte == $past(i_rx_byte))
        else $error("accepted item not held in the input register");
`endif

endmodule

// ===== rtl/core/sfd_cfg.sv =====
// ----------------------------------------------------------------------------
// sfd_cfg
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
module sfd_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sfd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sfd_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output sfd_pkg::t_cfg                 o_cfg
);
    import sfd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.receive_enable <= RST_RX_ENABLE;
            r_cfg.first_sync     <= RST_FIRST_SYNC;
            r_cfg.second_sync    <= RST_SECOND_SYNC;
            r_cfg.max_payload    <= RST_MAX_PAYLOAD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RX_ENABLE:   r_cfg.receive_enable <= i_cfg_wdata[0];
                CFG_FIRST_SYNC:  r_cfg.first_sync     <= i_cfg_wdata[7:0];
                CFG_SECOND_SYNC: r_cfg.second_sync    <= i_cfg_wdata[7:0];
                CFG_MAX_PAYLOAD: r_cfg.max_payload    <= i_cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/sfd_parser.sv =====
// ----------------------------------------------------------------------------
// sfd_parser
// Frame phase machine with held header fields and the running CRC.
// ----------------------------------------------------------------------------
module sfd_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  sfd_pkg::t_cfg    i_cfg,
    output sfd_pkg::t_result o_result
);
    import sfd_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_type, n_type;
    logic [15:0] r_seq, n_seq;
    logic [15:0] r_len, n_len;
    logic [15:0] r_taken, n_taken;
    logic [15:0] r_rx_crc, n_rx_crc;
    logic [15:0] r_crc, n_crc;
    logic [15:0] len_full;
    logic [15:0] taken_inc;
    logic [15:0] rx_crc_full;
    logic [15:0] crc_next;
    logic        ok;
    logic        go;

    assign go          = i_step && i_cfg.receive_enable;
    assign crc_next    = crc16_step(r_crc, i_byte);
    assign len_full    = {r_len[15:8], i_byte};
    assign taken_inc   = r_taken + 16'd1;
    assign rx_crc_full = {i_byte, r_rx_crc[7:0]};
    assign ok          = (rx_crc_full == r_crc);

    always_comb begin
        n_phase  = r_phase;
        n_type   = r_type;
        n_seq    = r_seq;
        n_len    = r_len;
        n_taken  = r_taken;
        n_rx_crc = r_rx_crc;
        n_crc    = r_crc;
        o_result = '0;
        o_result.frame_type     = r_type;
        o_result.sequence_res   = r_seq;
        o_result.payload_length = r_len;
        case (r_phase)
            PH_SYNC1: begin
                if (i_byte == i_cfg.second_sync) begin
                    n_phase = PH_TYPE;
                end else if (i_byte != i_cfg.first_sync) begin
                    n_phase = PH_SYNC0;
                end
            end
            PH_TYPE: begin
                n_type  = i_byte;
                n_crc   = crc16_step(CRC_INIT, i_byte);
                n_phase = PH_SEQ_HI;
            end
            PH_SEQ_HI: begin
                n_seq   = {i_byte, 8'h00};
                n_crc   = crc_next;
                n_phase = PH_SEQ_LO;
            end
            PH_SEQ_LO: begin
                n_seq   = {r_seq[15:8], i_byte};
                n_crc   = crc_next;
                n_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_len   = {i_byte, 8'h00};
                n_crc   = crc_next;
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_len   = len_full;
                n_crc   = crc_next;
                n_taken = '0;
                if (len_full > i_cfg.max_payload) begin
                    n_phase = PH_SYNC0;
                end else if (len_full == 16'd0) begin
                    n_phase = PH_CRC_LO;
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_crc   = crc_next;
                n_taken = taken_inc;
                if (taken_inc >= r_len) begin
                    n_phase = PH_CRC_LO;
                end
                o_result.valid     = 1'b1;
                o_result.kind      = KIND_DATA;
                o_result.data_byte = i_byte;
            end
            PH_CRC_LO: begin
                n_rx_crc = {8'h00, i_byte};
                n_phase  = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                o_result.valid        = 1'b1;
                o_result.kind         = KIND_REPORT;
                o_result.crc_ok       = ok;
                o_result.is_ack       = ok && (r_type == TYPE_ACK);
                o_result.ack_required = ok && (r_type != TYPE_ACK) && type_reliable(r_type);
                n_phase  = PH_SYNC0;
                n_type   = '0;
                n_seq    = '0;
                n_len    = '0;
                n_taken  = '0;
                n_rx_crc = '0;
                n_crc    = CRC_INIT;
            end
            default: begin
                n_phase = (i_byte == i_cfg.first_sync) ? PH_SYNC1 : PH_SYNC0;
            end
        endcase
        o_result.valid = o_result.valid && go;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SYNC0;
            r_type   <= '0;
            r_seq    <= '0;
            r_len    <= '0;
            r_taken  <= '0;
            r_rx_crc <= '0;
            r_crc    <= CRC_INIT;
        end else if (go) begin
            r_phase  <= n_phase;
            r_type   <= n_type;
            r_seq    <= n_seq;
            r_len    <= n_len;
            r_taken  <= n_taken;
            r_rx_crc <= n_rx_crc;
            r_crc    <= n_crc;
        end
    end

endmodule

// ===== sim/sfd_deframe_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_deframe_checker
// Watches the byte and result channels of the sync frame deframer. It keeps
// its own parser with a bit-serial CRC16-XMODEM and queues the payload bytes
// and frame reports that each accepted byte should produce. Every accepted
// result is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module sfd_deframe_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sfd_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [7:0]                     i_rx_byte,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic                           i_kind,
    input  logic [7:0]                     i_data_byte,
    input  logic [7:0]                     i_frame_type,
    input  logic [15:0]                    i_sequence_res,
    input  logic [15:0]                    i_payload_length,
    input  logic                           i_crc_ok,
    input  logic                           i_is_ack,
    input  logic                           i_ack_required,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_reports,
    output int                             o_good_reports,
    output int                             o_payload_bytes
);

    import sfd_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [7:0]  frame_type;
        logic [15:0] sequence_res;
        logic [15:0] payload_length;
        logic        crc_ok;
        logic        is_ack;
        logic        ack_required;
    } t_deframed;

    t_deframed   deframed_q[$];
    t_cfg        cfg;
    t_phase      phase;
    logic [7:0]  f_type;
    logic [15:0] f_seq;
    logic [15:0] f_len;
    logic [15:0] f_count;
    logic [15:0] f_rx_crc;
    logic [15:0] f_crc;
    int          err_count = 0;
    int          report_count = 0;
    int          good_count = 0;
    int          payload_count = 0;

    function automatic logic [15:0] xmodem_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    function automatic logic wants_ack(input logic [7:0] t);
        case (t)
            TYPE_U02, TYPE_ACK, TYPE_U20, TYPE_U21, TYPE_U30, TYPE_U33: return 1'b0;
            default: return 1'b1;
        endcase
    endfunction

    function automatic int field_diff(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    task automatic clear_frame_state();
        phase    = PH_SYNC0;
        f_type   = 8'h00;
        f_seq    = 16'h0000;
        f_len    = 16'h0000;
        f_count  = 16'h0000;
        f_rx_crc = 16'h0000;
        f_crc    = CRC_INIT;
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        case (idx)
            CFG_RX_ENABLE:   cfg.receive_enable = d[0];
            CFG_FIRST_SYNC:  cfg.first_sync     = d[7:0];
            CFG_SECOND_SYNC: cfg.second_sync    = d[7:0];
            CFG_MAX_PAYLOAD: cfg.max_payload    = d;
            default: ;
        endcase
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        t_deframed r;
        logic      ok;
        if (cfg.receive_enable) begin
            r = '0;
            case (phase)
                PH_SYNC1: begin
                    if (b == cfg.second_sync)
                        phase = PH_TYPE;
                    else if (b != cfg.first_sync)
                        phase = PH_SYNC0;
                end
                PH_TYPE: begin
                    f_type = b;
                    f_crc  = xmodem_next(CRC_INIT, b);
                    phase  = PH_SEQ_HI;
                end
                PH_SEQ_HI: begin
                    f_seq = {b, 8'h00};
                    f_crc = xmodem_next(f_crc, b);
                    phase = PH_SEQ_LO;
                end
                PH_SEQ_LO: begin
                    f_seq[7:0] = b;
                    f_crc      = xmodem_next(f_crc, b);
                    phase      = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    f_len = {b, 8'h00};
                    f_crc = xmodem_next(f_crc, b);
                    phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    f_len[7:0] = b;
                    f_crc      = xmodem_next(f_crc, b);
                    f_count    = 16'h0000;
                    if (f_len > cfg.max_payload)
                        phase = PH_SYNC0;
                    else if (f_len == 16'h0000)
                        phase = PH_CRC_LO;
                    else
                        phase = PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    f_crc   = xmodem_next(f_crc, b);
                    f_count = f_count + 16'd1;
                    if (f_count >= f_len)
                        phase = PH_CRC_LO;
                    r.kind           = KIND_DATA;
                    r.data_byte      = b;
                    r.frame_type     = f_type;
                    r.sequence_res   = f_seq;
                    r.payload_length = f_len;
                    deframed_q.push_back(r);
                end
                PH_CRC_LO: begin
                    f_rx_crc = {8'h00, b};
                    phase    = PH_CRC_HI;
                end
                PH_CRC_HI: begin
                    f_rx_crc[15:8]   = b;
                    ok               = (f_rx_crc == f_crc);
                    r.kind           = KIND_REPORT;
                    r.frame_type     = f_type;
                    r.sequence_res   = f_seq;
                    r.payload_length = f_len;
                    r.crc_ok         = ok;
                    r.is_ack         = ok && (f_type == TYPE_ACK);
                    r.ack_required   = ok && wants_ack(f_type);
                    deframed_q.push_back(r);
                    clear_frame_state();
                end
                default: phase = (b == cfg.first_sync) ? PH_SYNC1 : PH_SYNC0;
            endcase
        end
    endtask

    task automatic check_result();
        t_deframed want;
        int        bad;
        if (deframed_q.size() == 0) begin
            $error("result item with kind %0d arrived while none was expected", i_kind);
            err_count++;
        end else begin
            want = deframed_q.pop_front();
            bad  = field_diff("kind", 16'(want.kind), 16'(i_kind))
                 + field_diff("data_byte", 16'(want.data_byte), 16'(i_data_byte))
                 + field_diff("frame_type", 16'(want.frame_type), 16'(i_frame_type))
                 + field_diff("sequence_res", want.sequence_res, i_sequence_res)
                 + field_diff("payload_length", want.payload_length, i_payload_length)
                 + field_diff("crc_ok", 16'(want.crc_ok), 16'(i_crc_ok))
                 + field_diff("is_ack", 16'(want.is_ack), 16'(i_is_ack))
                 + field_diff("ack_required", 16'(want.ack_required), 16'(i_ack_required));
            if (bad != 0)
                err_count++;
            if (want.kind == KIND_REPORT) begin
                report_count++;
                if (want.crc_ok)
                    good_count++;
            end else begin
                payload_count++;
            end
        end
    endtask

    // Results are compared before the new byte is parsed, since no byte can
    // produce its result at the edge where it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.receive_enable = RST_RX_ENABLE;
            cfg.first_sync     = RST_FIRST_SYNC;
            cfg.second_sync    = RST_SECOND_SYNC;
            cfg.max_payload    = RST_MAX_PAYLOAD;
            clear_frame_state();
            deframed_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall)
                check_result();
            if (i_cfg_we)
                write_cfg(i_cfg_index, i_cfg_wdata);
            if (i_in_valid && !i_in_stall)
                deframe_byte(i_rx_byte);
        end
        o_fail_count    <= err_count;
        o_pending       <= deframed_q.size();
        o_reports       <= report_count;
        o_good_reports  <= good_count;
        o_payload_bytes <= payload_count;
    end

endmodule

// ===== sim/sync_frame_deframer_crc16_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_frame_deframer_crc16_tb
// Drives framed byte streams into the deframer under several sync and length
// settings, with random gaps and output stalls, a long output hold-off and a
// disabled stretch. A separate checker predicts and compares the results.
// ----------------------------------------------------------------------------
module sync_frame_deframer_crc16_tb;

    import sfd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [7:0]            rx_byte = 8'h00;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  kind;
    logic [7:0]            data_byte;
    logic [7:0]            frame_type;
    logic [15:0]           sequence_res;
    logic [15:0]           payload_length;
    logic                  crc_ok;
    logic                  is_ack;
    logic                  ack_required;

    int fail_count;
    int pending;
    int n_reports;
    int n_good;
    int n_payload;
    int cycle_count = 0;
    int sent_count = 0;
    int settings_count = 0;

    bit          rx_on = 1'b1;
    bit          tx_burst = 1'b0;
    bit          rx_burst = 1'b0;
    bit          hold_request = 1'b0;
    logic [7:0]  sync_a = RST_FIRST_SYNC;
    logic [7:0]  sync_b = RST_SECOND_SYNC;
    logic [15:0] max_len_now = RST_MAX_PAYLOAD;

    sync_frame_deframer_crc16 dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_wdata      (cfg_wdata),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_rx_byte        (rx_byte),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_kind           (kind),
        .o_data_byte      (data_byte),
        .o_frame_type     (frame_type),
        .o_sequence_res   (sequence_res),
        .o_payload_length (payload_length),
        .o_crc_ok         (crc_ok),
        .o_is_ack         (is_ack),
        .o_ack_required   (ack_required)
    );

    sfd_deframe_checker u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_wdata      (cfg_wdata),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_rx_byte        (rx_byte),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_kind           (kind),
        .i_data_byte      (data_byte),
        .i_frame_type     (frame_type),
        .i_sequence_res   (sequence_res),
        .i_payload_length (payload_length),
        .i_crc_ok         (crc_ok),
        .i_is_ack         (is_ack),
        .i_ack_required   (ack_required),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_reports        (n_reports),
        .o_good_reports   (n_good),
        .o_payload_bytes  (n_payload)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Run timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [7:0] payload_byte();
        logic [31:0] r;
        r = $urandom();
        case (r[10:8])
            3'd0: return 8'h00;
            3'd1: return 8'hFF;
            default: return r[7:0];
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge i_clk); while (in_stall);
        if (rx_on)
            sent_count++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_settings(input bit en, input logic [7:0] fs, input logic [7:0] ss,
                                  input logic [15:0] mx);
        logic [31:0] r;
        drain_results();
        r = $urandom();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RX_ENABLE;
        cfg_wdata <= {r[15:1], en};
        @(posedge i_clk);
        cfg_index <= CFG_FIRST_SYNC;
        cfg_wdata <= {r[23:16], fs};
        @(posedge i_clk);
        cfg_index <= CFG_SECOND_SYNC;
        cfg_wdata <= {r[31:24], ss};
        @(posedge i_clk);
        cfg_index <= CFG_MAX_PAYLOAD;
        cfg_wdata <= mx;
        @(posedge i_clk);
        cfg_we      <= 1'b0;
        rx_on       = en;
        sync_a      = fs;
        sync_b      = ss;
        max_len_now = mx;
        settings_count++;
    endtask

    // A length above the limit ends the frame after the length bytes. A
    // nonzero cut sends only the first bytes of the frame.
    task automatic send_frame(input logic [7:0] t, input logic [15:0] seq,
                              input logic [15:0] len, input bit bad_crc,
                              input int repeats, input int cut);
        logic [7:0]  fb[$];
        logic [15:0] crc;
        fb.push_back(sync_a);
        repeat (repeats) fb.push_back(sync_a);
        fb.push_back(sync_b);
        fb.push_back(t);
        fb.push_back(seq[15:8]);
        fb.push_back(seq[7:0]);
        fb.push_back(len[15:8]);
        fb.push_back(len[7:0]);
        crc = CRC_INIT;
        for (int i = repeats + 2; i < fb.size(); i++)
            crc = crc16_step(crc, fb[i]);
        if (len <= max_len_now) begin
            for (int i = 0; i < len; i++) begin
                fb.push_back(payload_byte());
                crc = crc16_step(crc, fb[fb.size() - 1]);
            end
            if (bad_crc)
                crc = crc ^ (16'h0001 << $urandom_range(0, 15));
            fb.push_back(crc[7:0]);
            fb.push_back(crc[15:8]);
        end
        if (cut <= 0 || cut > fb.size())
            cut = fb.size();
        for (int i = 0; i < cut; i++)
            send_byte(fb[i]);
    endtask

    task automatic random_traffic(input int goal);
        logic [31:0] r;
        logic [7:0]  t;
        int          pick;
        int          len;
        int          repeats;
        int          cut;
        while (sent_count < goal) begin
            tx_burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 4)) send_byte(payload_byte());
            if ($urandom_range(0, 39) == 0)
                drain_results();
            r = $urandom();
            case (r[3:0])
                4'd0: t = TYPE_U02;
                4'd1: t = TYPE_ACK;
                4'd2: t = TYPE_U20;
                4'd3: t = TYPE_U21;
                4'd4: t = TYPE_U30;
                4'd5: t = TYPE_U33;
                default: t = r[15:8];
            endcase
            pick = $urandom_range(0, 19);
            if (pick < 2)
                len = 0;
            else if (pick < 14)
                len = $urandom_range(1, 8);
            else if (pick < 18)
                len = $urandom_range(9, 40);
            else if (pick == 18)
                len = (max_len_now <= 64) ? max_len_now : $urandom_range(1, 8);
            else if (max_len_now < 16'hFFFF)
                len = $urandom_range(max_len_now + 1, 65535);
            else
                len = $urandom_range(9, 40);
            repeats = (sync_a != sync_b && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            cut = (max_len_now < 1024 && $urandom_range(0, 11) == 0) ? $urandom_range(1, 8) : 0;
            send_frame(t, r[31:16], 16'(len), ($urandom_range(0, 4) == 0), repeats, cut);
        end
    endtask

    // The receiver stalls for a random count before each result item, in
    // stretches of no stalling, and once holds off for a long while.
    initial begin
        int n;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                out_stall <= 1'b0;
            end else begin
                n = rx_burst ? 0 : $urandom_range(0, 7);
                if (n > 0) begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                    out_stall <= 1'b0;
                end
            end
            do @(posedge i_clk); while (!out_valid);
            if ($urandom_range(0, 31) == 0)
                rx_burst = ~rx_burst;
        end
    end

    initial begin
        logic [31:0] r;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_frame(TYPE_ACK, 16'h0000, 16'd0, 1'b0, 0, 0);
        send_frame(8'h80, 16'hFFFF, 16'd2, 1'b0, 2, 0);
        send_frame(8'h01, 16'h1234, RST_MAX_PAYLOAD + 16'd1, 1'b0, 0, 0);

        write_settings(1'b1, RST_FIRST_SYNC, RST_SECOND_SYNC, RST_MAX_PAYLOAD);
        hold_request = 1'b1;
        tx_burst     = 1'b1;
        send_frame(8'h42, 16'h0101, 16'd80, 1'b0, 0, 0);
        drain_results();
        random_traffic(sent_count + 330);

        // Nothing sent while reception is off may change the parser.
        write_settings(1'b0, RST_FIRST_SYNC, RST_SECOND_SYNC, RST_MAX_PAYLOAD);
        repeat (20) send_byte(payload_byte());
        send_frame(8'h01, 16'h0001, 16'd3, 1'b0, 0, 0);

        write_settings(1'b1, 8'h00, 8'hFF, 16'd0);
        random_traffic(sent_count + 200);
        write_settings(1'b1, 8'hFF, 8'h00, 16'hFFFF);
        random_traffic(sent_count + 330);
        write_settings(1'b1, 8'h5A, 8'h5A, 16'd16);
        random_traffic(sent_count + 330);
        repeat (2) begin
            r = $urandom();
            write_settings(1'b1, r[7:0], r[15:8], {10'd0, r[21:16]} + 16'd1);
            random_traffic(sent_count + 255);
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        $display("Sent %0d bytes under %0d register settings, with a long output hold-off.",
                 sent_count, settings_count);
        $display("Checked %0d payload bytes and %0d frame reports, %0d with a good CRC.",
                 n_payload, n_reports, n_good);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
